@@ rtl/core/imuyaw_pkg.sv @@
package imuyaw_pkg;

   localparam int BYTE_W    = 8;
   localparam int HEADING_W = 9;
   localparam int POS_W     = 3;
   localparam int YAW_W     = 16;
   localparam int WORK_W    = 11;
   localparam int PROD_W    = 32;

   localparam logic [BYTE_W-1:0] FRAME_HEAD = 8'hAA;
   localparam logic [BYTE_W-1:0] FRAME_TAIL = 8'h55;

   localparam logic [POS_W-1:0] POS_HEAD   = 3'd0;
   localparam logic [POS_W-1:0] POS_YAW_HI = 3'd1;
   localparam logic [POS_W-1:0] POS_YAW_LO = 3'd2;
   localparam logic [POS_W-1:0] POS_TAIL   = 3'd7;

   // ceil(2^22 / 100); exact quotient for every magnitude up to 32768.
   localparam logic [YAW_W-1:0] RECIP_100   = 16'd41944;
   localparam int               RECIP_SHIFT = 22;

   localparam logic signed [WORK_W-1:0] HALF_TURN = 11'sd180;
   localparam logic signed [WORK_W-1:0] FULL_TURN = 11'sd360;

endpackage

@@ rtl/core/imu_yaw_frame_parser.sv @@
// Yaw frame parser for a serial orientation sensor.
//
// Bytes from the sensor link arrive as beats on the req_ channel. The parser
// hunts for header 0xAA, collects an 8-byte frame and, on the eighth byte,
// sends one beat on the rsp_ channel: the heading in whole degrees
// (-180..180) in rsp_tdata and the tail check in rsp_tuser. A bad tail
// repeats the last good heading. Bytes that do not complete a frame give no
// beat. csr_data sets heading reversal (half a turn); csr_ready is always high.
//
// Every byte passes an input register; a tail byte then moves on to the result
// register, where its beat is presented, and waits while that register is full.
// One byte is taken every cycle unless a tail byte waits; the division by 100 is
// a single combinational reciprocal multiply from the yaw bytes to the result register.
//
// Synchronous reset empties both registers, returns the parser to the header
// search and clears the last good heading and reversal. While the receiver
// stalls, the result beat holds and header/payload bytes keep flowing in; a
// tail byte waits in the input register until the result register frees.
module imu_yaw_frame_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [imuyaw_pkg::BYTE_W-1:0]       req_tdata,   // [7:0] rx_byte
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [15:0]                         rsp_tdata,   // [8:0] heading_deg, zero above
   output logic                                rsp_tuser,   // [0] frame_ok
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic                                csr_data     // [0] reverse_heading
);
   import imuyaw_pkg::*;

   logic                          reverse_ff, reverse_in;
   logic                          in_vld_ff, in_vld_in;
   logic [BYTE_W-1:0]             in_byte_ff, in_byte_in;
   logic [POS_W-1:0]              pos_ff, pos_in;
   logic [BYTE_W-1:0]             yaw_hi_ff, yaw_hi_in;
   logic [BYTE_W-1:0]             yaw_lo_ff, yaw_lo_in;
   logic signed [HEADING_W-1:0]   last_heading_ff, last_heading_in;
   logic                          out_vld_ff, out_vld_in;
   logic signed [HEADING_W-1:0]   out_heading_ff, out_heading_in;
   logic                          out_ok_ff, out_ok_in;

   logic                          is_tail;
   logic                          out_free;
   logic                          advance;
   logic                          frame_ok;

   logic signed [YAW_W-1:0]       yaw;
   logic [YAW_W-1:0]              mag;
   logic [PROD_W-1:0]             prod;
   logic [WORK_W-2:0]             quot_mag;
   logic signed [WORK_W-1:0]      quot;
   logic signed [WORK_W-1:0]      turned;
   logic signed [WORK_W-1:0]      wrapped;

   assign csr_ready  = 1'b1;
   assign reverse_in = (csr_valid && csr_ready) ? csr_data : reverse_ff;

   assign is_tail  = (pos_ff == POS_TAIL);
   assign out_free = !out_vld_ff || rsp_tready;
   // A tail byte needs room in the result register; every other byte moves on.
   assign advance  = in_vld_ff && (!is_tail || out_free);

   assign req_tready = !in_vld_ff || advance;

   always_comb begin
      in_vld_in  = in_vld_ff;
      in_byte_in = in_byte_ff;
      if (req_tready) begin
         in_vld_in  = req_tvalid;
         in_byte_in = req_tdata;
      end
   end

   // Heading arithmetic: signed divide by 100 through magnitude and reciprocal, then optional reversal and wrap.
   always_comb begin
      yaw      = $signed({yaw_hi_ff, yaw_lo_ff});
      mag      = yaw[YAW_W-1] ? YAW_W'(-yaw) : YAW_W'(yaw);
      prod     = PROD_W'(mag) * PROD_W'(RECIP_100);
      quot_mag = prod[RECIP_SHIFT +: (WORK_W-1)];
      quot     = yaw[YAW_W-1] ? -$signed({1'b0, quot_mag}) : $signed({1'b0, quot_mag});
      turned   = quot;
      if (reverse_ff) begin
         turned = (quot > 0) ? quot - HALF_TURN : quot + HALF_TURN;
      end
      wrapped = turned;
      if (turned > HALF_TURN) begin
         wrapped = turned - FULL_TURN;
      end else if (turned < -HALF_TURN) begin
         wrapped = turned + FULL_TURN;
      end
   end

   assign frame_ok = (in_byte_ff == FRAME_TAIL);

   always_comb begin
      pos_in          = pos_ff;
      yaw_hi_in       = yaw_hi_ff;
      yaw_lo_in       = yaw_lo_ff;
      last_heading_in = last_heading_ff;
      out_vld_in      = out_vld_ff && !rsp_tready;
      out_heading_in  = out_heading_ff;
      out_ok_in       = out_ok_ff;
      if (advance) begin
         if (pos_ff == POS_HEAD) begin
            if (in_byte_ff == FRAME_HEAD) begin
               pos_in = POS_YAW_HI;
            end
         end else if (is_tail) begin
            pos_in     = POS_HEAD;
            out_vld_in = 1'b1;
            out_ok_in  = frame_ok;
            if (frame_ok) begin
               last_heading_in = wrapped[HEADING_W-1:0];
               out_heading_in  = wrapped[HEADING_W-1:0];
            end else begin
               out_heading_in = last_heading_ff;
            end
         end else begin
            pos_in = pos_ff + 1'b1;
            if (pos_ff == POS_YAW_HI) begin
               yaw_hi_in = in_byte_ff;
            end
            if (pos_ff == POS_YAW_LO) begin
               yaw_lo_in = in_byte_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reverse_ff      <= 1'b0;
         in_vld_ff       <= 1'b0;
         pos_ff          <= POS_HEAD;
         last_heading_ff <= '0;
         out_vld_ff      <= 1'b0;
      end else begin
         reverse_ff      <= reverse_in;
         in_vld_ff       <= in_vld_in;
         pos_ff          <= pos_in;
         last_heading_ff <= last_heading_in;
         out_vld_ff      <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff     <= in_byte_in;
      yaw_hi_ff      <= yaw_hi_in;
      yaw_lo_ff      <= yaw_lo_in;
      out_heading_ff <= out_heading_in;
      out_ok_ff      <= out_ok_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{(16-HEADING_W){1'b0}}, out_heading_ff};
   assign rsp_tuser  = out_ok_ff;

   // The pending beat always carries the current last good heading.
   a_rsp_matches_last : assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> (out_heading_ff == last_heading_ff))
      else $error("result heading differs from last good heading");

   a_heading_range : assert property (@(posedge clock) disable iff (reset)
      out_vld_ff |-> (out_heading_ff >= -9'sd180) && (out_heading_ff <= 9'sd180))
      else $error("heading outside -180..180");

   a_pos_holds : assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(pos_ff))
      else $error("frame position moved without a byte");

   a_tail_waits : assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && is_tail && !out_free) |=> (in_vld_ff && is_tail))
      else $error("tail byte lost while result stalled");

endmodule

@@ tb/heading_checker.sv @@
module heading_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [imuyaw_pkg::BYTE_W-1:0] req_tdata,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [15:0]                   rsp_tdata,
   input  logic                          rsp_tuser,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic                          csr_data,
   output int                            mismatch_count,
   output int                            pending_count
);
   import imuyaw_pkg::*;

   localparam int CENTI_PER_DEG = 100;
   localparam int HALF_TURN_DEG = 180;
   localparam int FULL_TURN_DEG = 360;

   typedef struct {
      logic signed [HEADING_W-1:0] heading;
      logic                        frame_ok;
   } heading_beat_type;

   heading_beat_type            expected_headings[$];
   logic [POS_W-1:0]            frame_pos;
   logic [BYTE_W-1:0]           yaw_hi;
   logic [BYTE_W-1:0]           yaw_lo;
   logic signed [HEADING_W-1:0] good_heading;
   logic                        reverse_on;

   function automatic logic signed [HEADING_W-1:0] yaw_to_heading(
      input logic [BYTE_W-1:0] hi,
      input logic [BYTE_W-1:0] lo,
      input logic              reverse
   );
      logic signed [YAW_W-1:0] yaw;
      int                      deg;
      yaw = signed'({hi, lo});
      // Integer division truncates toward zero, as the sensor format expects.
      deg = int'(yaw) / CENTI_PER_DEG;
      if (reverse) begin
         if (deg > 0) deg = deg - HALF_TURN_DEG;
         else deg = deg + HALF_TURN_DEG;
      end
      if (deg > HALF_TURN_DEG) deg = deg - FULL_TURN_DEG;
      if (deg < -HALF_TURN_DEG) deg = deg + FULL_TURN_DEG;
      return HEADING_W'(deg);
   endfunction

   always @(posedge clock) begin
      heading_beat_type want;
      if (reset) begin
         frame_pos      = POS_HEAD;
         yaw_hi         = '0;
         yaw_lo         = '0;
         good_heading   = '0;
         reverse_on     = 1'b0;
         mismatch_count = 0;
         expected_headings.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_headings.size() == 0) begin
               $display("%0t: result beat with none expected: got heading %0d ok %0b",
                        $time, $signed(rsp_tdata[HEADING_W-1:0]), rsp_tuser);
               mismatch_count++;
            end else begin
               want = expected_headings.pop_front();
               if (rsp_tdata !== {{(16-HEADING_W){1'b0}}, want.heading}) begin
                  $display("%0t: heading mismatch: expected %0d, got %0d (tdata %h)",
                           $time, want.heading, $signed(rsp_tdata[HEADING_W-1:0]),
                           rsp_tdata);
                  mismatch_count++;
               end
               if (rsp_tuser !== want.frame_ok) begin
                  $display("%0t: frame_ok mismatch: expected %0b, got %0b",
                           $time, want.frame_ok, rsp_tuser);
                  mismatch_count++;
               end
            end
         end

         // The user must make register writes only while the parser is idle; neither block enforces it.
         if (csr_valid && csr_ready) reverse_on = csr_data;

         if (req_tvalid && req_tready) begin
            if (frame_pos == POS_HEAD) begin
               if (req_tdata == FRAME_HEAD) frame_pos = POS_YAW_HI;
            end else if (frame_pos == POS_TAIL) begin
               want.frame_ok = (req_tdata == FRAME_TAIL);
               if (want.frame_ok) good_heading = yaw_to_heading(yaw_hi, yaw_lo, reverse_on);
               want.heading = good_heading;
               expected_headings.push_back(want);
               frame_pos = POS_HEAD;
            end else begin
               if (frame_pos == POS_YAW_HI) yaw_hi = req_tdata;
               if (frame_pos == POS_YAW_LO) yaw_lo = req_tdata;
               frame_pos = frame_pos + 1'b1;
            end
         end
      end
      pending_count = expected_headings.size();
   end

endmodule

@@ tb/testbench.sv @@
module testbench;
   import imuyaw_pkg::*;

   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int SQUEEZE_CYCLES = 80;
   localparam int PHASE_ITEMS   = 90;
   localparam int YAW_CORNERS [15] = '{0, -1, 99, 100, -99, -100, 17999, 18000, 18099,
                                        18100, -18000, -18099, -18100, 32767, -32768};

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [BYTE_W-1:0] req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [15:0]       rsp_tdata;
   logic              rsp_tuser;
   logic              csr_valid;
   logic              csr_ready;
   logic              csr_data;
   int                mismatch_count;
   int                pending_count;
   int                idle_cycles;
   logic              steady;
   logic              squeeze;
   logic              squeezed;

   imu_yaw_frame_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   heading_checker scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Mostly short gaps, now and then a long one; none at all in steady stretches.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (steady) return 0;
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 25);
   endfunction

   task automatic send_byte(input logic [BYTE_W-1:0] value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_frame(input logic [YAW_W-1:0] yaw, input logic [BYTE_W-1:0] tail);
      send_byte(FRAME_HEAD);
      send_byte(yaw[15:8]);
      send_byte(yaw[7:0]);
      repeat (4) send_byte(BYTE_W'($urandom_range(255)));
      send_byte(tail);
   endtask

   task automatic write_reverse(input logic value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Wait for every expected heading, then let the pipeline drain.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_frames(input int items);
      int                sent;
      int                cut;
      logic [YAW_W-1:0]  yaw;
      logic [BYTE_W-1:0] tail;
      sent = 0;
      while (sent < items) begin
         // Noise between frames; a stray header byte here breaks the next frame.
         if ($urandom_range(99) < 15)
            repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom_range(255)));
         if ($urandom_range(99) < 8) begin
            cut = $urandom_range(1, 6);
            send_byte(FRAME_HEAD);
            repeat (cut) send_byte(BYTE_W'($urandom_range(255)));
            sent += cut + 1;
         end
         if ($urandom_range(99) < 30) yaw = YAW_W'(YAW_CORNERS[$urandom_range(14)]);
         else yaw = YAW_W'($urandom_range(16'hFFFF));
         if ($urandom_range(99) < 80) tail = FRAME_TAIL;
         else tail = BYTE_W'($urandom_range(255));
         send_frame(yaw, tail);
         sent += 8;
      end
   endtask

   initial begin
      rsp_tready = 1'b0;
      squeezed   = 1'b0;
      forever begin
         @(negedge clock);
         if (squeeze && !squeezed) begin
            rsp_tready <= 1'b0;
            repeat (SQUEEZE_CYCLES) @(negedge clock);
            squeezed = 1'b1;
            rsp_tready <= 1'b1;
         end else if (!steady && $urandom_range(99) < 25) begin
            rsp_tready <= 1'b0;
            repeat (pick_gap() + 1) @(negedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_data   = 1'b0;
      steady     = 1'b0;
      squeeze    = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Junk before any header, then the yaw extremes (the negative one with a bad tail) and 18100, which wraps.
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(FRAME_TAIL);
      send_frame(16'h7FFF, FRAME_TAIL);
      send_frame(16'h8000, FRAME_HEAD);
      send_frame(YAW_W'(18100), FRAME_TAIL);
      settle();

      for (int phase = 0; phase < 4; phase++) begin
         write_reverse(phase % 2 == 0);
         steady = (phase == 2);
         if (phase == 1) squeeze = 1'b1;
         run_frames(PHASE_ITEMS);
         settle();
      end

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

@@ imu_yaw_frame_parser.f @@
rtl/core/imuyaw_pkg.sv
rtl/core/imu_yaw_frame_parser.sv
tb/heading_checker.sv
tb/testbench.sv
